### rtl/core/ordered_array_table_engine_top_macros.svh
// assertion macros used by the ordered array table engine checker
`ifndef ORDERED_ARRAY_TABLE_ENGINE_TOP_MACROS_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define OATE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("oate check failed");

// next-cycle implication
`define OATE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("oate check failed");

`endif

### rtl/core/oate_pkg.sv
// shared constants and types of the ordered array table engine
`timescale 1ns / 1ps

package oate_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 7;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 7;
    localparam int FIDX_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SEARCH = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

endpackage

### rtl/core/oate_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module oate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ordered_array_table_engine_top.sv
// ordered array table engine: packed signed word table with append, insert, delete, search
`timescale 1ns / 1ps

// Usage
// - command channel: drive mode, position and value with start; the beat is taken at an
//   edge where start is high and busy is low
// - result channel: done pulses for one cycle with status, found_index and length; the
//   receiver cannot stall, so every result must be taken in that cycle
// - config port: apb-style, capacity at byte address 0; pready is tied high; write only
//   while the block is idle
// - append, a full table and a bad position: result in the cycle after the beat, busy
//   stays low, so a new beat may follow every cycle
// - insert at p: busy while the entries from the top down to p move up one place; when p is
//   length+1 nothing moves; the result comes in the first cycle with busy low
// - delete at p: busy while the entries above p move down; nothing moves when p is length
// - search: busy while the scan runs up from index 0; it stops at the first hit, covers
//   the whole table on a miss and reads nothing on an empty table
// - every walk uses one ram port pair and moves one entry per cycle
// - reset: table empty, capacity 64; entries are not cleared and need no clearing pass

module ordered_array_table_engine_top import oate_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              mode,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VAL_W-1:0] value,
    output logic                    done,
    output logic [1:0]              status,
    output logic [FIDX_W-1:0]       found_index,
    output logic [LEN_W-1:0]        length
);

    state_t               state_reg,  state_next;
    mode_t                op_reg,     op_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     count_reg,  count_next;
    logic [IDX_W-1:0]     ptr_reg,    ptr_next;
    logic [IDX_W-1:0]     tag_reg,    tag_next;
    logic [CNT_W-1:0]     rem_reg,    rem_next;
    logic                 pend_reg,   pend_next;
    logic [WORD_BITS-1:0] word_reg,   word_next;
    logic [IDX_W-1:0]     ins_reg,    ins_next;
    logic                 done_reg,   done_next;
    status_t              status_reg, status_next;
    logic [IDX_W-1:0]     found_reg,  found_next;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     cap_ext;
    logic [CMP_W-1:0]     limit;
    logic [CMP_W-1:0]     pos_ext;
    logic                 full;
    logic                 ins_bad;
    logic                 del_bad;
    logic [WORD_BITS-1:0] word_in;
    logic                 cfg_wr;

    oate_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // config port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : DATA_W'(cap_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr && !paddr[2])
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // request checks
    assign count_ext = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(cap_reg);
    assign limit     = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);
    assign full      = count_ext >= limit;
    assign pos_ext   = CMP_W'(position);
    assign ins_bad   = (pos_ext == '0) || ((pos_ext - CMP_W'(1)) > count_ext);
    assign del_bad   = (pos_ext == '0) || (pos_ext > count_ext);
    assign word_in   = WORD_BITS'(value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ptr_reg    <= ptr_next;
        tag_reg    <= tag_next;
        word_reg   <= word_next;
        ins_reg    <= ins_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        tag_next    = tag_reg;
        rem_next    = rem_reg;
        pend_next   = pend_reg;
        word_next   = word_reg;
        ins_next    = ins_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = mode_t'(mode);
                    word_next   = word_in;
                    ins_next    = IDX_W'(pos_ext - CMP_W'(1));
                    pend_next   = 1'b0;
                    found_next  = '0;
                    status_next = ST_DONE;
                    case (mode_t'(mode))
                        MODE_APPEND:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = IDX_W'(count_reg);
                                mem_wdata  = word_in;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (full)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (ins_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                // walk down from the top entry to the insert point
                                ptr_next   = IDX_W'(count_ext - CMP_W'(1));
                                rem_next   = CNT_W'(count_ext - pos_ext + CMP_W'(1));
                                state_next = S_RUN;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (del_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                ptr_next   = IDX_W'(pos_ext);
                                rem_next   = CNT_W'(count_ext - pos_ext);
                                state_next = S_RUN;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            ptr_next   = '0;
                            rem_next   = count_reg;
                            state_next = S_RUN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // write back the entry read in the previous cycle
                if (pend_reg && (op_reg != MODE_SEARCH))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tag_reg;
                    mem_wdata = mem_rdata;
                end

                if (pend_reg && (op_reg == MODE_SEARCH) && (mem_rdata == word_reg))
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    found_next  = tag_reg;
                    pend_next   = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (rem_reg != '0)
                begin
                    mem_raddr = ptr_reg;
                    pend_next = 1'b1;
                    rem_next  = rem_reg - CNT_W'(1);
                    case (op_reg)
                        MODE_INSERT:
                        begin
                            tag_next = ptr_reg + IDX_W'(1);
                            ptr_next = ptr_reg - IDX_W'(1);
                        end
                        MODE_DELETE:
                        begin
                            tag_next = ptr_reg - IDX_W'(1);
                            ptr_next = ptr_reg + IDX_W'(1);
                        end
                        default:
                        begin
                            tag_next = ptr_reg;
                            ptr_next = ptr_reg + IDX_W'(1);
                        end
                    endcase
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = '0;
                    state_next = S_IDLE;
                    case (op_reg)
                        MODE_INSERT:
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = ins_reg;
                            mem_wdata   = word_reg;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_DONE;
                        end
                        MODE_DELETE:
                        begin
                            count_next  = count_reg - CNT_W'(1);
                            status_next = ST_DONE;
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_index = FIDX_W'(found_reg);
    assign length      = LEN_W'(count_reg);

endmodule

### rtl/core/oate_checker.sv
// port-level checker for the ordered array table engine, bound to the top level
`timescale 1ns / 1ps
`include "ordered_array_table_engine_top_macros.svh"

module oate_checker import oate_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [1:0]        status,
    input logic [FIDX_W-1:0] found_index
);

    // a result is only shown once the walk is over
    `OATE_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy)

    // an accepted beat either answers at once or starts a walk
    `OATE_ASSERT_NXT(a_accept_moves, clk, rst_n, start && !busy, busy || done)

    // a walk never ends without a result
    `OATE_ASSERT_NXT(a_busy_ends_done, clk, rst_n, busy, busy || done)

    // only a successful request reports an index
    `OATE_ASSERT_IMP(a_index_zero, clk, rst_n, done && (status != ST_DONE), found_index == '0)

endmodule

bind ordered_array_table_engine_top oate_checker u_oate_checker (.*);

### tb/ordered_array_table_engine_top_tb.sv
// testbench for the ordered array table engine: scoreboard class, directed and random requests
`timescale 1ns / 1ps

module ordered_array_table_engine_top_tb;
    import oate_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 80;

    localparam logic [ADDR_W-1:0]       ADDR_CAPACITY = '0;
    localparam logic signed [VAL_W-1:0] VAL_MIN       = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX       = 32'sh7fff_ffff;

    typedef struct {
        status_t            status;
        logic [FIDX_W-1:0]  found;
        logic [LEN_W-1:0]   len;
    } reply_t;

    // shadow table that predicts the reply of every request and checks the replies
    class reply_checker;
        int unsigned          cap;
        int unsigned          count;
        logic [WORD_BITS-1:0] entries [DEPTH];
        reply_t               replies_due [$];
        int unsigned          errors;

        function new();
            cap    = CAP_RESET;
            count  = 0;
            errors = 0;
            foreach (entries[i])
            begin
                entries[i] = '0;
            end
        endfunction

        function void note_request(mode_t m, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            reply_t               r;
            int unsigned          limit;
            int unsigned          p;
            logic [WORD_BITS-1:0] w;
            bit                   hit;
            limit    = (cap < DEPTH) ? cap : DEPTH;
            p        = pos;
            w        = WORD_BITS'(val);
            hit      = 1'b0;
            r.status = ST_DONE;
            r.found  = '0;
            case (m)
                MODE_APPEND:
                begin
                    if (count >= limit)
                        r.status = ST_FULL;
                    else
                    begin
                        entries[count] = w;
                        count++;
                    end
                end
                MODE_INSERT:
                begin
                    // full is reported ahead of a bad position
                    if (count >= limit)
                        r.status = ST_FULL;
                    else if (p == 0 || p > count + 1)
                        r.status = ST_BAD_POS;
                    else
                    begin
                        for (int unsigned i = count; i > p - 1; i--)
                            entries[i] = entries[i - 1];
                        entries[p - 1] = w;
                        count++;
                    end
                end
                MODE_DELETE:
                begin
                    if (p == 0 || p > count)
                        r.status = ST_BAD_POS;
                    else
                    begin
                        for (int unsigned i = p - 1; i + 1 < count; i++)
                            entries[i] = entries[i + 1];
                        count--;
                    end
                end
                default:
                begin
                    r.status = ST_NOT_FOUND;
                    for (int unsigned i = 0; i < count && !hit; i++)
                    begin
                        if (entries[i] == w)
                        begin
                            hit      = 1'b1;
                            r.status = ST_DONE;
                            r.found  = FIDX_W'(i);
                        end
                    end
                end
            endcase
            r.len = LEN_W'(count);
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [FIDX_W-1:0] fi, logic [LEN_W-1:0] ln);
            reply_t e;
            if (replies_due.size() == 0)
            begin
                $error("reply with no request waiting: status %0d length %0d", st, ln);
                errors++;
                return;
            end
            e = replies_due.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                errors++;
            end
            if (fi !== e.found)
            begin
                $error("found_index: expected %0d, actual %0d", e.found, fi);
                errors++;
            end
            if (ln !== e.len)
            begin
                $error("length: expected %0d, actual %0d", e.len, ln);
                errors++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [ADDR_W-1:0]       paddr    = '0;
    logic [DATA_W-1:0]       pwdata   = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    start    = 1'b0;
    logic                    busy;
    logic [1:0]              mode     = '0;
    logic [POS_W-1:0]        position = '0;
    logic signed [VAL_W-1:0] value    = '0;
    logic                    done;
    logic [1:0]              status;
    logic [FIDX_W-1:0]       found_index;
    logic [LEN_W-1:0]        length;

    reply_checker sb;
    int unsigned  quiet_cycles = 0;

    ordered_array_table_engine_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .position    (position),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .length      (length)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_reply(status, found_index, length);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable && pwrite) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // drop start and put junk on the request fields
    task automatic hold_off(int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start    <= 1'b0;
            mode     <= 2'($urandom_range(0, 3));
            position <= POS_W'($urandom_range(0, 64));
            value    <= $urandom;
        end
    endtask

    task automatic issue_request(mode_t m, logic [POS_W-1:0] p, logic signed [VAL_W-1:0] v);
        @(negedge clk);
        start    <= 1'b1;
        mode     <= m;
        position <= p;
        value    <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(m, p, v);
    endtask

    task automatic settle_table();
        hold_off(1);
        while (sb.pending() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= DATA_W'(cap);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.cap = cap;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r >= 55)
            return $urandom;
        case ($urandom_range(0, 7))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 5;
            6:       return -7;
            default: return 100;
        endcase
    endfunction

    task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned n,
                             int unsigned add_pct, int unsigned del_pct);
        int unsigned             len;
        int unsigned             r;
        int unsigned             hi;
        mode_t                   m;
        logic [POS_W-1:0]        p;
        logic signed [VAL_W-1:0] v;
        settle_table();
        write_capacity(cap);
        for (int unsigned k = 0; k < n; k++)
        begin
            // every 64 beats a stretch of 16 runs back to back
            if ((k % 64) >= 16)
            begin
                r = $urandom_range(0, 99);
                if (r >= 95)
                    hold_off($urandom_range(20, 120));
                else if (r >= 60)
                    hold_off($urandom_range(1, 3));
            end
            len = sb.count;
            r   = $urandom_range(0, 99);
            if (r < add_pct)
                m = ($urandom_range(0, 1) == 0) ? MODE_APPEND : MODE_INSERT;
            else if (r < add_pct + del_pct)
                m = MODE_DELETE;
            else
                m = MODE_SEARCH;
            p = POS_W'($urandom_range(0, 64));
            if ($urandom_range(0, 9) != 0)
            begin
                if (m == MODE_INSERT)
                begin
                    hi = (len + 1 > DEPTH) ? DEPTH : len + 1;
                    p  = POS_W'($urandom_range(1, hi));
                end
                else if (m == MODE_DELETE && len > 0)
                    p = POS_W'($urandom_range(1, len));
            end
            if (m == MODE_SEARCH && len > 0 && $urandom_range(0, 9) < 7)
                v = sb.entries[$urandom_range(0, len - 1)];
            else
                v = pick_value();
            issue_request(m, p, v);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table
        issue_request(MODE_SEARCH, 7'd0, 32'sd5);
        issue_request(MODE_DELETE, 7'd1, 32'sd0);
        issue_request(MODE_INSERT, 7'd0, 32'sd3);
        issue_request(MODE_INSERT, 7'd2, 32'sd3);
        issue_request(MODE_INSERT, 7'd1, VAL_MIN);
        issue_request(MODE_APPEND, 7'd64, VAL_MAX);
        issue_request(MODE_APPEND, 7'd0, -32'sd1);
        issue_request(MODE_INSERT, 7'd4, 32'sd0);
        issue_request(MODE_INSERT, 7'd2, -32'sd1);
        // first match wins on duplicates
        issue_request(MODE_SEARCH, 7'd0, -32'sd1);
        issue_request(MODE_SEARCH, 7'd127, 32'sd0);
        issue_request(MODE_SEARCH, 7'd0, 32'sd12345);
        issue_request(MODE_DELETE, 7'd6, 32'sd0);
        issue_request(MODE_DELETE, 7'd5, 32'sd0);
        issue_request(MODE_DELETE, 7'd1, 32'sd0);
        issue_request(MODE_DELETE, 7'd0, 32'sd0);
        issue_request(MODE_INSERT, 7'd64, 32'sd9);

        // capacity below the length: adds report full until deletes catch up
        settle_table();
        write_capacity(7'd2);
        issue_request(MODE_APPEND, 7'd0, 32'sd7);
        issue_request(MODE_INSERT, 7'd9, 32'sd7);
        issue_request(MODE_DELETE, 7'd3, 32'sd0);
        issue_request(MODE_APPEND, 7'd0, 32'sd7);
        issue_request(MODE_DELETE, 7'd1, 32'sd0);
        issue_request(MODE_APPEND, 7'd0, 32'sd7);

        settle_table();
        write_capacity(7'd0);
        issue_request(MODE_APPEND, 7'd0, 32'sd1);
        issue_request(MODE_INSERT, 7'd1, 32'sd1);
        issue_request(MODE_SEARCH, 7'd0, VAL_MAX);

        run_phase(7'd64, 200, 70, 15);
        run_phase(7'd127, 190, 45, 35);
        run_phase(7'd1, 150, 40, 40);
        run_phase(7'd0, 60, 40, 30);
        run_phase(7'd64, 200, 75, 10);
        run_phase(7'd5, 150, 35, 45);
        run_phase(7'd33, 200, 45, 35);
        run_phase(7'd64, 200, 20, 60);
        run_phase(CAP_W'($urandom_range(1, 64)), 200, 45, 35);

        settle_table();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
